// ----- hw/rtl/jds_pkg.sv -----
// Joint drive supervisor package: widths, action and register codes, beat types.
// Shared by the supervisor top level and the testbench; depends on nothing else.
package jds_pkg;

	// Fixed sizes
	localparam int TICK_W       = 32;
	localparam int SCHEME_COUNT = 8;
	localparam int SCHEME_W     = 3;
	localparam int CFG_W        = 32;
	localparam int BAND_W       = 15;
	localparam int SPEED_W      = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CMP_W        = (TICK_W > CFG_W) ? TICK_W : CFG_W;

	// Action codes
	typedef enum logic [3:0] {
		A_NONE     = 4'd0,
		A_SENDSYNC = 4'd1,
		A_START    = 4'd2,
		A_STOP     = 4'd3,
		A_SELECT   = 4'd4,
		A_QSTOP    = 4'd5,
		A_PWMOFF   = 4'd6,
		A_BOOT     = 4'd7,
		A_COMPUTE  = 4'd8
	} action_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PING_TIMEOUT = 3'd0,
		REG_SYNCH_PERIOD = 3'd1,
		REG_BRAKE_HOLD   = 3'd2,
		REG_DEAD_BAND    = 3'd3,
		REG_INDEX_SCHEME = 3'd4,
		REG_BRAKE_SCHEME = 3'd5
	} reg_idx_t;

	// Latched master requests
	typedef struct packed {
		logic stop;
		logic start;
		logic sel;
		logic upd;
		logic sync;
	} req_t;

	// Status flags
	typedef struct packed {
		logic idx;
		logic moff;
		logic run;
		logic safe;
	} flags_t;

	// One input beat
	typedef struct packed {
		logic                      sync_pulse;
		logic                      update_pulse;
		logic                      select_pulse;
		logic [SCHEME_W-1:0]       select_number;
		logic                      start_pulse;
		logic                      stop_pulse;
		logic                      ping_pulse;
		logic                      encoder_indexed;
		logic                      limit_violation;
		logic signed [SPEED_W-1:0] joint_speed;
	} in_item_t;

	// Interval test: clock not below the mark and distance at least the limit
	function automatic logic elapsed(input logic [TICK_W-1:0] now,
		input logic [TICK_W-1:0] mark, input logic [CFG_W-1:0] limit);
		logic [TICK_W-1:0] diff;
		diff = now - mark;
		return (now >= mark) && (CMP_W'(diff) >= CMP_W'(limit));
	endfunction

	// Scheme ids keep their low three bits; eight schemes fill them, so none saturate
	function automatic logic [SCHEME_W-1:0] clamp_id(input logic [CFG_W-1:0] v);
		logic [SCHEME_W-1:0] lo;
		lo = v[SCHEME_W-1:0];
		return (CMP_W'(lo) >= CMP_W'(SCHEME_COUNT)) ?
			SCHEME_W'(SCHEME_COUNT - 1) : lo;
	endfunction

endpackage

// ----- hw/rtl/joint_drive_supervisor_fsm.sv -----
// Joint drive supervisor: request latches, ping watchdog, mode machine, brake hold.
// A beat is captured in the input register, its result in the output register.
// Throughput: one beat per cycle unless the receiver stalls; the input register
// and the result register let a new tick in while the previous result still waits.
// Reset: mode stop, safe set, all requests clear, ping seen, clocks and marks zero,
// configuration back to its defaults.
module joint_drive_supervisor_fsm
	import jds_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        sync_pulse,
	input  logic                        update_pulse,
	input  logic                        select_pulse,
	input  logic [SCHEME_W-1:0]         select_number,
	input  logic                        start_pulse,
	input  logic                        stop_pulse,
	input  logic                        ping_pulse,
	input  logic                        encoder_indexed,
	input  logic                        limit_violation,
	input  logic signed [SPEED_W-1:0]   joint_speed,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  mode,
	output logic [3:0]                  action,
	output logic [SCHEME_W-1:0]         active_scheme,
	output logic                        motor_off_report,
	output logic                        stopped_report,
	output logic                        status
);

	typedef enum logic [3:0] {
		M_OUTSYNC   = 4'd0,
		M_SYNCHED   = 4'd1,
		M_UNINDEXED = 4'd2,
		M_IDLE      = 4'd3,
		M_UPDATE    = 4'd4,
		M_SELECT    = 4'd5,
		M_START     = 4'd6,
		M_RUN       = 4'd7,
		M_BRAKE     = 4'd8,
		M_BRAKING   = 4'd9,
		M_EMERG     = 4'd10,
		M_STOP      = 4'd11
	} mode_t;

	// configuration registers
	logic [CFG_W-1:0]    ping_timeout_q, synch_period_q, brake_hold_q;
	logic [BAND_W-1:0]   dead_band_q;
	logic [SCHEME_W-1:0] index_scheme_q, brake_scheme_q;

	// input stage
	logic     item_vld_s1;
	in_item_t item_s1;
	logic     advance;

	// supervisor state
	mode_t               mode_q;
	req_t                req_q;
	flags_t              flags_q;
	logic [SCHEME_W-1:0] chosen_q, active_q;
	logic [TICK_W-1:0]   tick_q, ping_mark_q, brake_mark_q;
	logic                ping_seen_q, still_q;

	// next state
	mode_t               n_mode;
	req_t                n_req;
	flags_t              n_flags;
	logic [SCHEME_W-1:0] n_chosen, n_active;
	logic [TICK_W-1:0]   n_tick, n_ping_mark, n_brake_mark;
	logic                n_ping_seen, n_still;
	action_t             n_action;
	logic                n_moff_rep, n_stop_rep, n_status;
	logic [SPEED_W-1:0]  speed_mag;

	// result stage
	logic                out_vld_s2;
	mode_t               mode_s2;
	action_t             action_s2;
	logic [SCHEME_W-1:0] active_s2;
	logic                moff_rep_s2, stop_rep_s2, status_s2;

	// handshakes
	assign cfg_ready = 1'b1;
	assign advance   = item_vld_s1 && (!out_vld_s2 || out_ready);
	assign in_ready  = !item_vld_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_timeout_q <= CFG_W'(1000);
			synch_period_q <= CFG_W'(100);
			brake_hold_q   <= CFG_W'(500);
			dead_band_q    <= BAND_W'(64);
			index_scheme_q <= clamp_id(CFG_W'(0));
			brake_scheme_q <= clamp_id(CFG_W'(1));
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PING_TIMEOUT: ping_timeout_q <= cfg_data;
				REG_SYNCH_PERIOD: synch_period_q <= cfg_data;
				REG_BRAKE_HOLD:   brake_hold_q   <= cfg_data;
				REG_DEAD_BAND:    dead_band_q    <= cfg_data[BAND_W-1:0];
				REG_INDEX_SCHEME: index_scheme_q <= clamp_id(cfg_data);
				REG_BRAKE_SCHEME: brake_scheme_q <= clamp_id(cfg_data);
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			item_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{sync_pulse, update_pulse, select_pulse, select_number,
				start_pulse, stop_pulse, ping_pulse, encoder_indexed,
				limit_violation, joint_speed};
		end
	end

	// speed magnitude; the most negative value maps to its unsigned magnitude
	assign speed_mag = item_s1.joint_speed[SPEED_W-1] ?
		SPEED_W'(-item_s1.joint_speed) : SPEED_W'(item_s1.joint_speed);

	// one tick: latch requests, watchdog, then one mode step
	always_comb begin
		n_mode       = mode_q;
		n_req        = req_q;
		n_flags      = flags_q;
		n_chosen     = chosen_q;
		n_active     = active_q;
		n_tick       = tick_q + TICK_W'(1);
		n_ping_mark  = ping_mark_q;
		n_brake_mark = brake_mark_q;
		n_ping_seen  = ping_seen_q | item_s1.ping_pulse;
		n_still      = still_q;
		n_action     = A_NONE;
		n_moff_rep   = 1'b0;
		n_stop_rep   = 1'b0;
		n_status     = 1'b0;

		// request latches
		if (item_s1.sync_pulse)   n_req.sync  = 1'b1;
		if (item_s1.update_pulse) n_req.upd   = 1'b1;
		if (item_s1.select_pulse &&
			(CMP_W'(item_s1.select_number) < CMP_W'(SCHEME_COUNT))) begin
			n_req.sel = 1'b1;
			n_chosen  = item_s1.select_number;
		end
		if (item_s1.start_pulse)  n_req.start = 1'b1;
		if (item_s1.stop_pulse)   n_req.stop  = 1'b1;

		// lost sync while running forces a stop
		if (!n_req.sync && n_flags.run) n_mode = M_STOP;

		// ping watchdog
		if (n_mode != M_OUTSYNC && elapsed(n_tick, n_ping_mark, ping_timeout_q)) begin
			if (!n_ping_seen) begin
				n_mode      = M_STOP;
				n_req       = '0;
				n_flags     = '{idx: n_flags.idx, moff: 1'b0, run: 1'b0, safe: 1'b1};
				n_ping_mark = '0;
				n_ping_seen = 1'b1;
				n_tick      = '0;
				n_status    = 1'b1;
			end else begin
				n_ping_mark = n_tick;
				n_ping_seen = 1'b0;
			end
		end

		n_flags.idx = item_s1.encoder_indexed;

		// mode step
		unique case (n_mode)
			M_OUTSYNC: begin
				if (elapsed(n_tick, '0, synch_period_q)) begin
					n_action = A_SENDSYNC;
					n_tick   = '0;
				end
				if (n_req.sync) n_mode = M_SYNCHED;
			end
			M_SYNCHED: begin
				n_ping_mark = n_tick;
				if (n_flags.idx) begin
					n_mode = M_IDLE;
				end else begin
					n_chosen = index_scheme_q;
					n_active = index_scheme_q;
					n_action = A_SELECT;
					n_mode   = M_UNINDEXED;
				end
			end
			M_UNINDEXED: begin
				if (n_req.upd) begin
					n_req.upd = 1'b0;
					n_mode    = M_UPDATE;
				end else if (n_flags.idx) begin
					n_mode = M_IDLE;
				end else if (n_req.start) begin
					n_req.start = 1'b0;
					n_mode      = M_START;
				end
			end
			M_IDLE: begin
				if (n_req.upd) begin
					n_req.upd = 1'b0;
					n_mode    = M_UPDATE;
				end else if (n_req.sel) begin
					n_req.sel = 1'b0;
					n_mode    = M_SELECT;
				end else if (n_req.start) begin
					n_req.start = 1'b0;
					n_mode      = M_START;
				end
			end
			M_UPDATE: begin
				n_action = A_BOOT;
				n_mode   = M_IDLE;
			end
			M_SELECT: begin
				n_active = n_chosen;
				n_action = A_SELECT;
				n_mode   = n_flags.run ? M_START : M_IDLE;
			end
			M_START: begin
				n_action     = A_START;
				n_tick       = '0;
				n_ping_mark  = '0;
				n_flags.run  = 1'b1;
				n_flags.moff = 1'b0;
				n_mode       = M_RUN;
			end
			M_RUN: begin
				n_action = A_COMPUTE;
				if (item_s1.limit_violation) n_flags.safe = 1'b0;
				if (!n_flags.safe) begin
					n_mode = M_EMERG;
				end else if (n_req.stop || (n_flags.idx && n_chosen == index_scheme_q)) begin
					n_req.stop = 1'b0;
					n_mode     = M_BRAKE;
				end else if (n_req.sel) begin
					n_req.sel = 1'b0;
					n_mode    = M_SELECT;
				end
			end
			M_BRAKE: begin
				n_stop_rep = 1'b1;
				n_active   = brake_scheme_q;
				n_still    = 1'b0;
				n_action   = A_QSTOP;
				n_mode     = M_BRAKING;
			end
			M_BRAKING: begin
				n_action = A_COMPUTE;
				if (item_s1.limit_violation) n_flags.safe = 1'b0;
				// hold timer: speed must stay inside the dead band
				if (speed_mag > SPEED_W'(dead_band_q)) begin
					n_still = 1'b0;
				end else if (!still_q) begin
					n_still      = 1'b1;
					n_brake_mark = n_tick;
				end else if (elapsed(n_tick, brake_mark_q, brake_hold_q)) begin
					n_action     = A_STOP;
					n_flags.moff = 1'b1;
					n_active     = n_chosen;
				end
				if (!n_flags.safe)     n_mode = M_EMERG;
				else if (n_flags.moff) n_mode = M_STOP;
			end
			M_EMERG: begin
				n_action     = A_PWMOFF;
				n_flags.moff = 1'b1;
				n_active     = n_chosen;
				n_mode       = M_STOP;
			end
			M_STOP: begin
				n_action    = A_STOP;
				n_flags.run = 1'b0;
				n_moff_rep  = 1'b1;
				if (!n_req.sync)       n_mode = M_OUTSYNC;
				else if (!n_flags.idx) n_mode = M_UNINDEXED;
				else                   n_mode = M_IDLE;
			end
			default: begin
				n_mode = M_STOP;
			end
		endcase
	end

	// supervisor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_STOP;
			req_q        <= '0;
			flags_q      <= '{idx: 1'b0, moff: 1'b0, run: 1'b0, safe: 1'b1};
			chosen_q     <= '0;
			active_q     <= '0;
			tick_q       <= '0;
			ping_mark_q  <= '0;
			brake_mark_q <= '0;
			ping_seen_q  <= 1'b1;
			still_q      <= 1'b0;
			out_vld_s2   <= 1'b0;
		end else begin
			if (advance) begin
				mode_q       <= n_mode;
				req_q        <= n_req;
				flags_q      <= n_flags;
				chosen_q     <= n_chosen;
				active_q     <= n_active;
				tick_q       <= n_tick;
				ping_mark_q  <= n_ping_mark;
				brake_mark_q <= n_brake_mark;
				ping_seen_q  <= n_ping_seen;
				still_q      <= n_still;
				out_vld_s2   <= 1'b1;
			end else if (out_ready) begin
				out_vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2     <= n_mode;
			action_s2   <= n_action;
			active_s2   <= n_active;
			moff_rep_s2 <= n_moff_rep;
			stop_rep_s2 <= n_stop_rep;
			status_s2   <= n_status;
		end
	end

	assign out_valid        = out_vld_s2;
	assign mode             = mode_s2;
	assign action           = action_s2;
	assign active_scheme    = active_s2;
	assign motor_off_report = moff_rep_s2;
	assign stopped_report   = stop_rep_s2;
	assign status           = status_s2;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the joint drive supervisor: directed ticks, then random ticks under
// several register settings, each beat checked against a typed row or a local mode predictor.
// Depends on jds_pkg and joint_drive_supervisor_fsm only.
`timescale 1ns / 1ps

module testbench;
	import jds_pkg::*;

	// Mode codes as driven on the mode port
	typedef enum logic [3:0] {
		MD_OUTSYNC   = 4'd0,
		MD_SYNCHED   = 4'd1,
		MD_UNINDEXED = 4'd2,
		MD_IDLE      = 4'd3,
		MD_UPDATE    = 4'd4,
		MD_SELECT    = 4'd5,
		MD_START     = 4'd6,
		MD_RUN       = 4'd7,
		MD_BRAKE     = 4'd8,
		MD_BRAKING   = 4'd9,
		MD_EMERG     = 4'd10,
		MD_STOP      = 4'd11
	} mode_t;

	// Register slots past the last defined one; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PHASES      = 6;
	localparam int PHASE_TICKS = 275;

	// One result beat
	typedef struct packed {
		mode_t               md;
		action_t             act;
		logic [SCHEME_W-1:0] sch;
		logic                moff;
		logic                stopr;
		logic                stat;
	} tick_result_t;

	typedef struct {
		in_item_t     tk;
		bit           typed;
		tick_result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic     in_valid = 1'b0;
	logic     in_ready;
	in_item_t tick_bus = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [3:0]          mode;
	logic [3:0]          action;
	logic [SCHEME_W-1:0] active_scheme;
	logic                motor_off_report;
	logic                stopped_report;
	logic                status;

	joint_drive_supervisor_fsm i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sync_pulse       (tick_bus.sync_pulse),
		.update_pulse     (tick_bus.update_pulse),
		.select_pulse     (tick_bus.select_pulse),
		.select_number    (tick_bus.select_number),
		.start_pulse      (tick_bus.start_pulse),
		.stop_pulse       (tick_bus.stop_pulse),
		.ping_pulse       (tick_bus.ping_pulse),
		.encoder_indexed  (tick_bus.encoder_indexed),
		.limit_violation  (tick_bus.limit_violation),
		.joint_speed      (tick_bus.joint_speed),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mode             (mode),
		.action           (action),
		.active_scheme    (active_scheme),
		.motor_off_report (motor_off_report),
		.stopped_report   (stopped_report),
		.status           (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Predictor copy of the registers
	logic [31:0]         to_ping, per_sync, hold_ticks;
	logic [BAND_W-1:0]   dead_band;
	logic [SCHEME_W-1:0] idx_scheme, brk_scheme;

	// Predictor copy of the supervisor state
	mode_t               sv_mode;
	logic                rq_sync, rq_upd, rq_sel, rq_start, rq_stop;
	logic                fl_safe, fl_run, fl_moff, fl_idx;
	logic [SCHEME_W-1:0] sch_chosen, sch_active;
	logic [31:0]         tick_now, ping_mark, brake_mark;
	logic                ping_seen, joint_still;

	tick_result_t tick_results_due [$];
	dir_row_t     dir_rows [$];

	int ticks_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int watchdog_resets = 0;
	int holds_done = 0;
	int settings_used = 1;
	int burst_left = 0;
	logic idx_level = 1'b1;

	// Interval test: clock not below the mark, distance at least the limit
	function automatic bit interval_done(input logic [31:0] now, input logic [31:0] mark,
		input logic [31:0] lim);
		return (now >= mark) && ((now - mark) >= lim);
	endfunction

	// Watchdog clear; the indexed flag and the scheme numbers survive
	task automatic clear_supervisor_flags();
		sv_mode = MD_STOP;
		{rq_sync, rq_upd, rq_sel, rq_start, rq_stop} = '0;
		fl_safe = 1'b1;
		fl_run = 1'b0;
		fl_moff = 1'b0;
		ping_mark = '0;
		ping_seen = 1'b1;
		tick_now = '0;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			REG_PING_TIMEOUT: to_ping = data;
			REG_SYNCH_PERIOD: per_sync = data;
			REG_BRAKE_HOLD:   hold_ticks = data;
			REG_DEAD_BAND:    dead_band = data[BAND_W-1:0];
			// eight schemes fill the three bits, so no saturation applies
			REG_INDEX_SCHEME: idx_scheme = data[SCHEME_W-1:0];
			REG_BRAKE_SCHEME: brk_scheme = data[SCHEME_W-1:0];
			default: ;
		endcase
	endtask

	// One control tick of the supervisor
	task automatic supervisor_tick(input in_item_t t, output tick_result_t r);
		int spd;
		int mag;
		spd = int'(t.joint_speed);
		mag = (spd < 0) ? -spd : spd;
		r = '{MD_STOP, A_NONE, '0, 1'b0, 1'b0, 1'b0};
		tick_now = tick_now + 32'd1;

		// latch request pulses
		if (t.sync_pulse) rq_sync = 1'b1;
		if (t.update_pulse) rq_upd = 1'b1;
		if (t.select_pulse) begin
			rq_sel = 1'b1;
			sch_chosen = t.select_number;
		end
		if (t.start_pulse) rq_start = 1'b1;
		if (t.stop_pulse) rq_stop = 1'b1;
		if (t.ping_pulse) ping_seen = 1'b1;

		// lost sync while running forces a stop
		if (!rq_sync && fl_run) sv_mode = MD_STOP;

		// ping watchdog
		if (sv_mode != MD_OUTSYNC && interval_done(tick_now, ping_mark, to_ping)) begin
			if (!ping_seen) begin
				clear_supervisor_flags();
				r.stat = 1'b1;
				watchdog_resets++;
			end else begin
				ping_mark = tick_now;
				ping_seen = 1'b0;
			end
		end

		fl_idx = t.encoder_indexed;

		case (sv_mode)
			MD_OUTSYNC: begin
				if (interval_done(tick_now, 32'd0, per_sync)) begin
					r.act = A_SENDSYNC;
					tick_now = '0;
				end
				if (rq_sync) sv_mode = MD_SYNCHED;
			end
			MD_SYNCHED: begin
				ping_mark = tick_now;
				if (fl_idx) begin
					sv_mode = MD_IDLE;
				end else begin
					sch_chosen = idx_scheme;
					sch_active = idx_scheme;
					r.act = A_SELECT;
					sv_mode = MD_UNINDEXED;
				end
			end
			MD_UNINDEXED: begin
				if (rq_upd) begin
					rq_upd = 1'b0;
					sv_mode = MD_UPDATE;
				end else if (fl_idx) begin
					sv_mode = MD_IDLE;
				end else if (rq_start) begin
					rq_start = 1'b0;
					sv_mode = MD_START;
				end
			end
			MD_IDLE: begin
				if (rq_upd) begin
					rq_upd = 1'b0;
					sv_mode = MD_UPDATE;
				end else if (rq_sel) begin
					rq_sel = 1'b0;
					sv_mode = MD_SELECT;
				end else if (rq_start) begin
					rq_start = 1'b0;
					sv_mode = MD_START;
				end
			end
			MD_UPDATE: begin
				r.act = A_BOOT;
				sv_mode = MD_IDLE;
			end
			MD_SELECT: begin
				sch_active = sch_chosen;
				r.act = A_SELECT;
				sv_mode = fl_run ? MD_START : MD_IDLE;
			end
			MD_START: begin
				r.act = A_START;
				tick_now = '0;
				ping_mark = '0;
				fl_run = 1'b1;
				fl_moff = 1'b0;
				sv_mode = MD_RUN;
			end
			MD_RUN: begin
				r.act = A_COMPUTE;
				if (t.limit_violation) fl_safe = 1'b0;
				if (!fl_safe) begin
					sv_mode = MD_EMERG;
				end else if (rq_stop || (fl_idx && sch_chosen == idx_scheme)) begin
					rq_stop = 1'b0;
					sv_mode = MD_BRAKE;
				end else if (rq_sel) begin
					rq_sel = 1'b0;
					sv_mode = MD_SELECT;
				end
			end
			MD_BRAKE: begin
				r.stopr = 1'b1;
				sch_active = brk_scheme;
				joint_still = 1'b0;
				r.act = A_QSTOP;
				sv_mode = MD_BRAKING;
			end
			MD_BRAKING: begin
				r.act = A_COMPUTE;
				if (t.limit_violation) fl_safe = 1'b0;
				// speed must sit inside the dead band for the whole hold time
				if (mag > int'(dead_band)) begin
					joint_still = 1'b0;
				end else if (!joint_still) begin
					joint_still = 1'b1;
					brake_mark = tick_now;
				end else if (interval_done(tick_now, brake_mark, hold_ticks)) begin
					r.act = A_STOP;
					fl_moff = 1'b1;
					sch_active = sch_chosen;
					holds_done++;
				end
				if (!fl_safe) sv_mode = MD_EMERG;
				else if (fl_moff) sv_mode = MD_STOP;
			end
			MD_EMERG: begin
				r.act = A_PWMOFF;
				fl_moff = 1'b1;
				sch_active = sch_chosen;
				sv_mode = MD_STOP;
			end
			MD_STOP: begin
				r.act = A_STOP;
				fl_run = 1'b0;
				r.moff = 1'b1;
				if (!rq_sync) sv_mode = MD_OUTSYNC;
				else if (!fl_idx) sv_mode = MD_UNINDEXED;
				else sv_mode = MD_IDLE;
			end
			default: sv_mode = MD_STOP;
		endcase

		r.md = sv_mode;
		r.sch = sch_active;
	endtask

	// Directed tick: pulses packed as {sync, update, select, start, stop, ping}
	function automatic in_item_t tick_of(input logic [5:0] pulses,
		input logic [SCHEME_W-1:0] num, input logic idx, input logic viol,
		input logic signed [SPEED_W-1:0] spd);
		in_item_t t;
		t = '0;
		{t.sync_pulse, t.update_pulse, t.select_pulse, t.start_pulse, t.stop_pulse,
			t.ping_pulse} = pulses;
		t.select_number = num;
		t.encoder_indexed = idx;
		t.limit_violation = viol;
		t.joint_speed = spd;
		return t;
	endfunction

	// Random tick: mostly plausible master traffic, a tenth pure noise
	task automatic make_random_tick(input int ping_pct, output in_item_t t);
		logic [31:0] noise;
		int spd;
		noise = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			t = noise[$bits(in_item_t)-1:0];
		end else begin
			if ($urandom_range(0, 19) == 0) idx_level = ~idx_level;
			t = '0;
			t.sync_pulse = ($urandom_range(0, 7) == 0);
			t.update_pulse = ($urandom_range(0, 29) == 0);
			t.select_pulse = ($urandom_range(0, 9) == 0);
			t.select_number = SCHEME_W'($urandom_range(0, SCHEME_COUNT - 1));
			t.start_pulse = ($urandom_range(0, 5) == 0);
			t.stop_pulse = ($urandom_range(0, 13) == 0);
			t.ping_pulse = ($urandom_range(1, 100) <= ping_pct);
			t.encoder_indexed = idx_level;
			t.limit_violation = ($urandom_range(0, 39) == 0);
			if ($urandom_range(0, 9) < 7) begin
				spd = int'($urandom_range(0, 600)) - 300;
				t.joint_speed = SPEED_W'(spd);
			end else begin
				t.joint_speed = noise[31:16];
			end
		end
	endtask

	// Present one tick and hold it until taken; the expectation follows
	task automatic feed_tick(input in_item_t t, input bit typed, input tick_result_t want);
		tick_result_t r;
		tick_bus <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		supervisor_tick(t, r);
		tick_results_due.push_back(typed ? want : r);
		ticks_sent++;
	endtask

	// Sender bursts with random gaps
	task automatic pace_sender();
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	task automatic drain_results();
		while (tick_results_due.size() != 0) @(posedge clk);
	endtask

	// Receiver stalls: a random style, redrawn whenever its countdown runs out
	int       stall_left = 0;
	int       stall_style = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_style <= $urandom_range(0, 3);
				stall_left <= $urandom_range(8, 63);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// Result checker
	tick_result_t got_res, want_res;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_res = '{mode_t'(mode), action_t'(action), active_scheme, motor_off_report,
				stopped_report, status};
			if (tick_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected (mode %0d action %0d)",
						$realtime, mode, action);
			end else begin
				want_res = tick_results_due.pop_front();
				results_checked++;
				if (got_res.md !== want_res.md || got_res.act !== want_res.act ||
					got_res.sch !== want_res.sch || got_res.moff !== want_res.moff ||
					got_res.stopr !== want_res.stopr || got_res.stat !== want_res.stat) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: result %0d expected mode %0d act %0d sch %0d moff %0d ",
							"stop %0d stat %0d, got %0d %0d %0d %0d %0d %0d"}, $realtime,
							results_checked, want_res.md, want_res.act, want_res.sch,
							want_res.moff, want_res.stopr, want_res.stat, got_res.md,
							got_res.act, got_res.sch, got_res.moff, got_res.stopr,
							got_res.stat);
				end
			end
		end
	end

	// Stimulus
	logic [31:0] reg_vals [8];
	int          ping_pct;
	in_item_t    rnd_tick;

	initial begin
		to_ping = 32'd1000;
		per_sync = 32'd100;
		hold_ticks = 32'd500;
		dead_band = 15'd64;
		idx_scheme = 3'd0;
		brk_scheme = 3'd1;
		fl_idx = 1'b0;
		clear_supervisor_flags();
		sch_chosen = '0;
		sch_active = '0;
		joint_still = 1'b0;
		brake_mark = '0;

		// sync upd sel start stop ping: run through every mode on the default settings
		dir_rows = '{
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b1,
				'{MD_OUTSYNC, A_STOP, 3'd0, 1'b1, 1'b0, 1'b0}},
			'{tick_of(6'b100000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b1,
				'{MD_SYNCHED, A_NONE, 3'd0, 1'b0, 1'b0, 1'b0}},
			'{tick_of(6'b000001, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b1,
				'{MD_IDLE, A_NONE, 3'd0, 1'b0, 1'b0, 1'b0}},
			'{tick_of(6'b010000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b001000, 3'd5, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000101, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000001, 3'd0, 1'b1, 1'b0, 16'sh7FFF), 1'b0, '0},
			'{tick_of(6'b001000, 3'd3, 1'b1, 1'b0, 16'sd100), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000010, 3'd0, 1'b1, 1'b0, 16'sh8000), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b1, 16'sd0), 1'b0, '0},
			// emergency brake after the violation
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b1,
				'{MD_STOP, A_PWMOFF, 3'd3, 1'b0, 1'b0, 1'b0}},
			'{tick_of(6'b000000, 3'd0, 1'b0, 1'b0, 16'sd0), 1'b1,
				'{MD_UNINDEXED, A_STOP, 3'd3, 1'b1, 1'b0, 1'b0}},
			// safe stays cleared, so a restart goes straight to emergency
			'{tick_of(6'b000100, 3'd0, 1'b0, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b0, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b0, 1'b0, -16'sd1), 1'b0, '0},
			'{tick_of(6'b001000, 3'd7, 1'b0, 1'b0, 16'sd0), 1'b0, '0},
			'{tick_of(6'b000000, 3'd0, 1'b1, 1'b0, 16'sd0), 1'b0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			feed_tick(dir_rows[i].tk, dir_rows[i].typed, dir_rows[i].want);
			pace_sender();
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// settle before touching registers
			in_valid <= 1'b0;
			drain_results();
			repeat (4) @(posedge clk);

			reg_vals[REG_SPARE_LO] = $urandom;
			reg_vals[REG_SPARE_HI] = $urandom;
			case (ph)
				0: begin
					reg_vals[REG_PING_TIMEOUT] = 32'd1;
					reg_vals[REG_SYNCH_PERIOD] = 32'd1;
					reg_vals[REG_BRAKE_HOLD] = 32'd0;
					reg_vals[REG_DEAD_BAND] = 32'd0;
					reg_vals[REG_INDEX_SCHEME] = 32'd0;
					reg_vals[REG_BRAKE_SCHEME] = 32'd0;
					ping_pct = 80;
				end
				1: begin
					reg_vals[REG_PING_TIMEOUT] = 32'hFFFF_FFFF;
					reg_vals[REG_SYNCH_PERIOD] = 32'hFFFF_FFFF;
					reg_vals[REG_BRAKE_HOLD] = 32'hFFFF_FFFF;
					reg_vals[REG_DEAD_BAND] = 32'd32767;
					reg_vals[REG_INDEX_SCHEME] = 32'd7;
					reg_vals[REG_BRAKE_SCHEME] = 32'd7;
					ping_pct = 50;
				end
				default: begin
					reg_vals[REG_PING_TIMEOUT] = $urandom_range(8, 80);
					reg_vals[REG_SYNCH_PERIOD] = $urandom_range(1, 12);
					reg_vals[REG_BRAKE_HOLD] = $urandom_range(0, 10);
					reg_vals[REG_DEAD_BAND] = $urandom_range(0, 400);
					reg_vals[REG_INDEX_SCHEME] = $urandom_range(0, 7);
					reg_vals[REG_BRAKE_SCHEME] = $urandom_range(0, 7);
					ping_pct = (ph % 2 == 1) ? 25 : 85;
				end
			endcase
			for (int k = 0; k < 8; k++)
				write_reg(CFG_IDX_W'(k), reg_vals[k]);
			cfg_valid <= 1'b0;
			settings_used++;

			for (int n = 0; n < PHASE_TICKS; n++) begin
				// one hold-off mid phase until every result is back
				if (ph == 3 && n == PHASE_TICKS / 2) begin
					in_valid <= 1'b0;
					drain_results();
					@(posedge clk);
				end
				make_random_tick(ping_pct, rnd_tick);
				feed_tick(rnd_tick, 1'b0, '0);
				pace_sender();
			end
		end

		in_valid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);

		$display("Ran %0d ticks (%0d directed) under %0d register settings, %0d results checked",
			ticks_sent, dir_rows.size(), settings_used, results_checked);
		$display("Predicted %0d watchdog resets and %0d completed brake holds",
			watchdog_resets, holds_done);
		if (mismatches == 0 && tick_results_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
